/* hdl/pli_pkg.sv */
// Shared constants and types for the piecewise linear interpolator.
`default_nettype none
package pli_pkg;
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [63:0] v;
    logic               inv;
  } entry_t;
endpackage
`default_nettype wire

/* hdl/pli_mem.sv */
// Sample table: one write port, one registered read port.
`default_nettype none
module pli_mem (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [pli_pkg::IDX_W-1:0] waddr_i,
  input  pli_pkg::entry_t          wdata_i,
  input  wire                      re_i,
  input  wire  [pli_pkg::IDX_W-1:0] raddr_i,
  output pli_pkg::entry_t          rdata_o
);
  import pli_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* hdl/pli_div.sv */
// Bit-serial signed 128 / unsigned 32 divider, quotient truncated to 64 bits.
`default_nettype none
module pli_div (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire  [127:0]  dividend_i,
  input  wire  [31:0]   divisor_i,
  output logic          done_o,
  output logic [63:0]   quot_o
);
  import pli_pkg::*;

  logic         busy_q, done_q;
  logic [6:0]   cnt_q;
  logic         neg_q;
  logic [127:0] mag_q;
  logic [31:0]  rem_q, div_q;
  logic [63:0]  quo_q;
  logic [32:0]  cur;
  logic [32:0]  diff;
  logic         ge;

  assign cur  = {rem_q, mag_q[127]};
  assign diff = cur - {1'b0, div_q};
  assign ge   = cur >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[127];
      mag_q <= dividend_i[127] ? (~dividend_i + 128'd1) : dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : cur[31:0];
      mag_q <= {mag_q[126:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 64'd1) : quo_q;
endmodule
`default_nettype wire

/* hdl/piecewise_linear_interpolator.sv */
// Piecewise linear interpolator: top level with scan, multiply and result control.
// A query scans the table from entry 0 through one registered memory read
// port, one entry per cycle; an exact match or no answer ends it there, and a
// bracket goes on to 32x32 partial products and the bit-serial divider. A
// full table holds 1024 entries. One item is worked on at a time; a finished
// word waits in the output register while the next item is taken.
`default_nettype none
module piecewise_linear_interpolator (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                req_type_i,
  input  wire                restart_i,
  input  wire  [31:0]        sample_time_i,
  input  wire  signed [63:0] sample_value_i,
  input  wire                sample_invalid_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [63:0] interp_value_o,
  output logic               interp_valid_o,
  output logic               table_overflowed_o
);
  import pli_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_MUL, ST_DIV, ST_RESULT} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q, issue_q, arr_q;
  logic               ovf_q, dv_q, have_prev_q;
  logic [31:0]        q_q;
  entry_t             prev_q, rd_data, wdata;
  logic signed [63:0] v0_q, v1_q, res_val_q;
  logic [31:0]        w0_q, w1_q, d_q;
  logic               res_ok_q;
  logic [2:0]         mk_q;
  logic [63:0]        prod_q;
  logic               prod_vld_q, prod_neg_q, prod_hi_q;
  logic [127:0]       acc_q, sh;
  logic               accept, app, qry;
  logic [CNT_W-1:0]   cnt_eff;
  logic               we, re;
  logic [IDX_W-1:0]   raddr;
  logic [63:0]        vsel, mag;
  logic [31:0]        part, wsel;
  logic               vneg, div_start, div_done;
  logic [63:0]        quot;
  logic               brk, exact, last;

  assign accept  = in_valid_i && !in_stall_o;
  assign app     = accept && (req_type_i == REQ_APPEND);
  assign qry     = accept && (req_type_i == REQ_QUERY);
  assign cnt_eff = restart_i ? '0 : cnt_q;
  assign we      = app && (cnt_eff < CNT_W'(CAPACITY));
  assign wdata   = '{t: sample_time_i, v: sample_value_i, inv: sample_invalid_i};

  // first read goes out with the query word itself
  assign re    = (qry && cnt_q != '0) || (state_q == ST_SCAN && issue_q < cnt_q);
  assign raddr = (state_q == ST_SCAN) ? issue_q[IDX_W-1:0] : '0;

  pli_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_eff[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);

  // bracket of the previous entry is checked before exact match of this one
  assign brk   = have_prev_q && (prev_q.t <= q_q) && (rd_data.t > q_q);
  assign exact = rd_data.t == q_q;
  assign last  = CNT_W'(arr_q + 1'b1) == cnt_q;

  assign vsel = (mk_q < 3'd2) ? v0_q : v1_q;
  assign vneg = vsel[63];
  assign mag  = vneg ? (~vsel + 64'd1) : vsel;
  assign part = mk_q[0] ? mag[63:32] : mag[31:0];
  assign wsel = (mk_q < 3'd2) ? w0_q : w1_q;
  assign sh   = prod_hi_q ? {32'd0, prod_q, 32'd0} : {64'd0, prod_q};
  assign div_start = (state_q == ST_MUL) && (mk_q == 3'd5);

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      dv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      issue_q     <= '0;
      arr_q       <= '0;
      mk_q        <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      dv_q       <= re;
      prod_vld_q <= 1'b0;
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (app) begin
            if (we) begin
              cnt_q <= cnt_eff + 1'b1;
              ovf_q <= restart_i ? 1'b0 : ovf_q;
            end else begin
              ovf_q <= 1'b1;
            end
          end else if (qry) begin
            q_q         <= sample_time_i;
            have_prev_q <= 1'b0;
            issue_q     <= CNT_W'(1);
            arr_q       <= '0;
            res_ok_q    <= 1'b0;
            res_val_q   <= '0;
            state_q     <= (cnt_q == '0) ? ST_RESULT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (re) begin
            issue_q <= issue_q + 1'b1;
          end
          if (dv_q) begin
            prev_q      <= rd_data;
            have_prev_q <= 1'b1;
            arr_q       <= arr_q + 1'b1;
            if (brk) begin
              if (prev_q.inv || rd_data.inv) begin
                state_q <= ST_RESULT;
              end else begin
                v0_q    <= prev_q.v;
                v1_q    <= rd_data.v;
                w0_q    <= rd_data.t - q_q;
                w1_q    <= q_q - prev_q.t;
                d_q     <= rd_data.t - prev_q.t;
                mk_q    <= '0;
                acc_q   <= '0;
                state_q <= ST_MUL;
              end
            end else if (exact) begin
              res_ok_q  <= !rd_data.inv;
              res_val_q <= rd_data.inv ? 64'sd0 : rd_data.v;
              state_q   <= ST_RESULT;
            end else if (last) begin
              state_q <= ST_RESULT;
            end
          end
        end
        ST_MUL: begin
          if (mk_q < 3'd4) begin
            prod_q     <= {32'd0, part} * {32'd0, wsel};
            prod_neg_q <= vneg;
            prod_hi_q  <= mk_q[0];
            prod_vld_q <= 1'b1;
          end
          if (prod_vld_q) begin
            acc_q <= prod_neg_q ? (acc_q - sh) : (acc_q + sh);
          end
          mk_q <= mk_q + 3'd1;
          if (div_start) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_ok_q  <= 1'b1;
            res_val_q <= quot;
            state_q   <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o        <= 1'b1;
            interp_value_o     <= res_ok_q ? res_val_q : 64'sd0;
            interp_valid_o     <= res_ok_q;
            table_overflowed_o <= ovf_q;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY)) else $error("entry count past capacity");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && state_q != ST_IDLE)) else $error("table write outside idle");
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !interp_valid_o) |-> (interp_value_o == 64'sd0))
    else $error("invalid word carries a value");
  a_div_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV)) else $error("divider start lost");
endmodule
`default_nettype wire

/* test/piecewise_linear_interpolator_test.sv */
// Self-checking testbench for the piecewise linear interpolator.
`timescale 1ns / 100ps
`default_nettype none
module piecewise_linear_interpolator_test;
  import pli_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  wire in_stall_o;
  logic req_type_i = REQ_APPEND;
  logic restart_i = 1'b0;
  logic [31:0] sample_time_i = '0;
  logic signed [63:0] sample_value_i = '0;
  logic sample_invalid_i = 1'b0;
  wire out_valid_o;
  logic out_stall_i = 1'b0;
  wire signed [63:0] interp_value_o;
  wire interp_valid_o;
  wire table_overflowed_o;

  piecewise_linear_interpolator DUT (.*);

  initial forever #4 clk_i = ~clk_i;

  typedef struct {
    logic signed [63:0] value;
    logic valid;
    logic ovf;
  } answer_t;

  answer_t answers_q[$];
  entry_t curve[CAPACITY];
  int n_entries = 0;
  logic ovf_flag = 1'b0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // Mirror of the block's query answer.
  function automatic answer_t interpolate(input logic [31:0] q);
    answer_t a;
    logic signed [127:0] num;
    logic signed [127:0] quo;
    logic [31:0] t0, t1;
    a.value = '0; a.valid = 1'b0; a.ovf = ovf_flag;
    for (int i = 0; i < n_entries; i++) begin
      t0 = curve[i].t;
      if (t0 == q) begin
        if (!curve[i].inv) begin
          a.value = curve[i].v; a.valid = 1'b1;
        end
        return a;
      end
      if (i + 1 < n_entries && t0 <= q && curve[i+1].t > q) begin
        t1 = curve[i+1].t;
        if (curve[i].inv || curve[i+1].inv) return a;
        num = 128'(curve[i].v) * $signed({96'd0, t1 - q})
            + 128'(curve[i+1].v) * $signed({96'd0, q - t0});
        quo = num / $signed({96'd0, t1 - t0});  // truncates toward zero
        a.value = quo[63:0]; a.valid = 1'b1;
        return a;
      end
    end
    return a;
  endfunction

  // Valid stays up after acceptance until the next call drives it in the same step.
  task automatic send_word(input logic rq, input logic rs, input logic [31:0] t,
                           input logic signed [63:0] v, input logic inv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; req_type_i <= rq; restart_i <= rs;
    sample_time_i <= t; sample_value_i <= v; sample_invalid_i <= inv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (rq == REQ_QUERY) answers_q.insert(answers_q.size(), interpolate(t));
    else begin
      if (rs) begin n_entries = 0; ovf_flag = 1'b0; end
      if (n_entries < CAPACITY) begin
        curve[n_entries] = '{t: t, v: v, inv: inv}; n_entries++;
      end else ovf_flag = 1'b1;
    end
  endtask

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {{32{1'b0}}, $urandom} - 64'sd2147483648;
      2: return $urandom_range(1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
      default: return (64'($signed($urandom_range(200))) <<< 32) - (64'sd100 <<< 32);
    endcase
  endfunction

  task automatic append(input logic rs, input logic [31:0] t, input logic signed [63:0] v,
                        input logic inv);
    send_word(REQ_APPEND, rs, t, v, inv);
  endtask

  task automatic query(input logic [31:0] t);
    send_word(REQ_QUERY, $urandom_range(1), t, rand_value(), $urandom_range(1));
  endtask

  task automatic test_directed();
    query(32'd5);  // empty table
    append(1'b1, 32'd0, 64'sh0000_0001_0000_0000, 1'b0);
    append(1'b0, 32'd10, 64'sh7fff_ffff_ffff_ffff, 1'b0);
    append(1'b0, 32'd20, 64'sh8000_0000_0000_0000, 1'b0);
    append(1'b0, 32'd30, 64'sh0000_0005_0000_0000, 1'b1);
    append(1'b0, 32'd25, -64'sd7, 1'b0);  // unsorted
    append(1'b0, 32'hffff_ffff, -64'sd12345, 1'b0);
    query(32'd0); query(32'd3); query(32'd10); query(32'd15);
    query(32'd22); query(32'd30); query(32'd27); query(32'd26);
    query(32'hffff_ffff); query(32'hffff_fffe);
    append(1'b1, 32'd0, 64'sh8000_0000_0000_0000, 1'b0);
    append(1'b0, 32'hffff_ffff, 64'sh7fff_ffff_ffff_ffff, 1'b0);
    query(32'h8000_0000); query(32'h0000_0001);
  endtask

  // Fill past capacity to exercise the overflow flag, then restart.
  task automatic test_overflow();
    for (int i = 0; i < CAPACITY + 3; i++)
      append(i == 0, 32'(i * 4), 64'($signed(i)) <<< 30, i % 97 == 5);
    query(32'd6); query(32'd4093); query(32'd9999);
    append(1'b1, 32'd100, 64'sd77, 1'b0);
    query(32'd100); query(32'd101);
  endtask

  task automatic test_random(input int items);
    int done = 0;
    logic [31:0] t;
    while (done < items) begin
      int len = $urandom_range(1, 12);
      logic [31:0] base = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
      t = base;
      append(1'b1, t, rand_value(), $urandom_range(7) == 0);
      for (int k = 1; k < len; k++) begin
        t = ($urandom_range(9) == 0) ? $urandom : t + $urandom_range(1, 50);
        append($urandom_range(30) == 0, t, rand_value(), $urandom_range(7) == 0);
      end
      done += len;
      for (int k = 0; k < 4; k++) begin
        query($urandom_range(4) == 0 ? $urandom : base + $urandom_range(0, 50 * len));
        done++;
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_q.size() == 0) begin
        $display("%0t unexpected word: value %h valid %b ovf %b", $time,
                 interp_value_o, interp_valid_o, table_overflowed_o);
        errors++;
      end else begin
        answer_t e;
        e = answers_q.pop_front();
        if (e.value !== interp_value_o || e.valid !== interp_valid_o ||
            e.ovf !== table_overflowed_o) begin
          $display("%0t mismatch: expected value %h valid %b ovf %b, got %h %b %b", $time,
                   e.value, e.valid, e.ovf, interp_value_o, interp_valid_o,
                   table_overflowed_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("piecewise_linear_interpolator_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 13; recv_idle_pct = 77;
    test_directed();
    test_random(180);
    send_idle_pct = 77; recv_idle_pct = 13;
    test_random(180);
    test_overflow();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(170);
    drain();
    if (errors == 0) $display("piecewise_linear_interpolator_test: done, clean");
    else $display("piecewise_linear_interpolator_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/pli_pkg.sv
hdl/pli_mem.sv
hdl/pli_div.sv
hdl/piecewise_linear_interpolator.sv
test/piecewise_linear_interpolator_test.sv
